// ----- src/lru_tag_cache_lookup_assert.svh -----
// Assertion macros used by the checker.
`ifndef LRU_TAG_CACHE_LOOKUP_ASSERT_SVH
`define LRU_TAG_CACHE_LOOKUP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define LTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LTC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/ltc_pkg.sv -----
package ltc_pkg;

  localparam int TagW   = 32;
  localparam int StampW = 32;
  localparam int OutIdxW = 4;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [StampW-1:0] STAMP_RESET = StampW'(1);

  typedef struct packed {
    logic [TagW-1:0]   tag_x;
    logic [TagW-1:0]   tag_y;
    logic [StampW-1:0] stamp;
  } ltc_entry_t;

endpackage

// ----- src/ltc_ram.sv -----
module ltc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/lru_tag_cache_lookup.sv -----
// Fully associative LRU tag cache over SLOTS entries, keyed by (sector_x, sector_y).
// A lookup (func 0) scans slots in order, one per cycle, through the read port of
// the tag/stamp RAM, whose read is registered, then writes the hit or victim entry
// back with a fresh stamp. A hit ends the scan at the matching slot; a miss scans
// every slot. The write and the result beat wait while a stalled result is held.
// A clear (func 1) drops all valid bits, resets the stamp counter to one and
// returns hit 0, slot 0 on the next cycle. One lookup is in progress at a time;
// no beat is taken while one runs. slot_index_o carries the low four bits of the
// slot number.
module lru_tag_cache_lookup
  import ltc_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [31:0] sector_x_i,
  input  logic signed [31:0] sector_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [3:0]         slot_index_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CtrW = IdxW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [CtrW-1:0]   ctr_q, ctr_d;
  logic [IdxW-1:0]   victim_q, victim_d;
  logic [StampW-1:0] vstamp_q, vstamp_d;
  logic [IdxW-1:0]   target_q, target_d;
  logic              res_hit_q, res_hit_d;
  logic [TagW-1:0]   key_x_q, key_x_d;
  logic [TagW-1:0]   key_y_q, key_y_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [IdxW-1:0]   out_slot_q, out_slot_d;

  logic              in_acc;
  logic              out_free;
  logic [IdxW-1:0]   cur;
  logic              cur_valid;
  logic              cur_match;
  logic              ram_we;
  ltc_entry_t        ram_wdata;
  ltc_entry_t        ram_rdata;
  logic [OutIdxW+IdxW-1:0] slot_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cur       = IdxW'(ctr_q - CtrW'(1));
  assign cur_valid = valid_q[cur];
  assign cur_match = cur_valid && (ram_rdata.tag_x == key_x_q) && (ram_rdata.tag_y == key_y_q);

  assign ram_we          = (state_q == ST_WRITE) && out_free;
  assign ram_wdata.tag_x = key_x_q;
  assign ram_wdata.tag_y = key_y_q;
  assign ram_wdata.stamp = stamp_q + StampW'(1);

  ltc_ram #(
    .Width ($bits(ltc_entry_t)),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (target_q),
    .wdata_i (ram_wdata),
    .raddr_i (ctr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    stamp_d     = stamp_q;
    ctr_d       = ctr_q;
    victim_d    = victim_q;
    vstamp_d    = vstamp_q;
    target_d    = target_q;
    res_hit_d   = res_hit_q;
    key_x_d     = key_x_q;
    key_y_d     = key_y_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;
    out_slot_d  = out_slot_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_CLEAR) begin
            valid_d     = '0;
            stamp_d     = STAMP_RESET;
            out_valid_d = 1'b1;
            out_hit_d   = 1'b0;
            out_slot_d  = '0;
          end else begin
            key_x_d  = sector_x_i;
            key_y_d  = sector_y_i;
            ctr_d    = '0;
            victim_d = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctr_d = ctr_q + CtrW'(1);
        if (ctr_q != '0) begin
          if (cur_match) begin
            target_d  = cur;
            res_hit_d = 1'b1;
            state_d   = ST_WRITE;
          end else begin
            if (!cur_valid || ctr_q == CtrW'(1) ||
                (valid_q[victim_q] && ram_rdata.stamp < vstamp_q)) begin
              victim_d = cur;
              vstamp_d = ram_rdata.stamp;
            end
            if (ctr_q == CtrW'(SLOTS)) begin
              target_d  = victim_d;
              res_hit_d = 1'b0;
              state_d   = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          valid_d[target_q] = 1'b1;
          stamp_d           = ram_wdata.stamp;
          out_valid_d       = 1'b1;
          out_hit_d         = res_hit_q;
          out_slot_d        = target_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      stamp_q     <= STAMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q      <= ctr_d;
    victim_q   <= victim_d;
    vstamp_q   <= vstamp_d;
    target_q   <= target_d;
    res_hit_q  <= res_hit_d;
    key_x_q    <= key_x_d;
    key_y_q    <= key_y_d;
    out_hit_q  <= out_hit_d;
    out_slot_q <= out_slot_d;
  end

  assign slot_ext     = {{OutIdxW{1'b0}}, out_slot_q};
  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign slot_index_o = slot_ext[OutIdxW-1:0];

endmodule

// ----- src/ltc_checker.sv -----
`include "lru_tag_cache_lookup_assert.svh"

module ltc_checker
  import ltc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               func_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               hit_o,
  input logic [3:0]         slot_index_o
);

  logic       in_beat;
  logic       clear_beat;
  logic       lookup_beat;
  logic       clear_out;
  logic       out_blocked;
  logic [4:0] out_word;

  assign in_beat     = in_valid_i && !in_stall_o;
  assign clear_beat  = in_beat && func_i == FUNC_CLEAR;
  assign lookup_beat = in_beat && func_i == FUNC_LOOKUP;
  assign clear_out   = out_valid_o && !hit_o && slot_index_o == 4'd0;
  assign out_blocked = out_valid_o && out_stall_i;
  assign out_word    = {hit_o, slot_index_o};

  `LTC_ASSERT_NEXT(a_clear_result, clear_beat, clear_out, "clear did not return hit 0 slot 0")
  `LTC_ASSERT_NEXT(a_lookup_busy, lookup_beat, in_stall_o, "accepted a beat during a lookup")
  `LTC_ASSERT_SAME(a_ready_out_free, !in_stall_o, !out_blocked, "ready while result is blocked")
  `LTC_ASSERT_NEXT(a_out_hold, out_blocked, out_valid_o && $stable(out_word), "stalled result changed")

endmodule

bind lru_tag_cache_lookup ltc_checker u_ltc_checker (.*);

// ----- tb/lru_tag_cache_lookup_tb.sv -----
`timescale 1ns / 1ps

module lru_tag_cache_lookup_tb;
  import ltc_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } slot_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               func_i = FUNC_LOOKUP;
  logic signed [31:0] sector_x_i = '0;
  logic signed [31:0] sector_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [3:0]         slot_index_o;

  // predictor state
  logic [SLOTS-1:0]  entry_live = '0;
  logic [TagW-1:0]   cached_x [SLOTS];
  logic [TagW-1:0]   cached_y [SLOTS];
  logic [StampW-1:0] last_use [SLOTS];
  logic [StampW-1:0] use_counter = STAMP_RESET;

  slot_result_t expected_slots[$];
  bit quiet = 1'b0;
  int errors = 0;
  int beats_checked = 0;
  int hits_seen = 0;
  int allocs_seen = 0;
  int evictions_seen = 0;
  int clears_seen = 0;

  lru_tag_cache_lookup #(.SLOTS(SLOTS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .sector_x_i  (sector_x_i),
    .sector_y_i  (sector_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .slot_index_o(slot_index_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic slot_result_t access_cache(input logic f, input logic [TagW-1:0] kx,
                                                input logic [TagW-1:0] ky);
    slot_result_t res;
    int victim;
    res = '0;
    if (f == FUNC_CLEAR) begin
      entry_live = '0;
      use_counter = STAMP_RESET;
      clears_seen++;
      return res;
    end
    victim = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (entry_live[i] && cached_x[i] == kx && cached_y[i] == ky) begin
        use_counter = use_counter + 1'b1;
        last_use[i] = use_counter;
        res.hit = 1'b1;
        res.slot = 4'(i);
        hits_seen++;
        return res;
      end
      if (!entry_live[i]) begin
        victim = i;
      end else if (entry_live[victim] && last_use[i] < last_use[victim]) begin
        victim = i;
      end
    end
    if (entry_live[victim]) evictions_seen++;
    allocs_seen++;
    entry_live[victim] = 1'b1;
    cached_x[victim] = kx;
    cached_y[victim] = ky;
    use_counter = use_counter + 1'b1;
    last_use[victim] = use_counter;
    res.slot = 4'(victim);
    return res;
  endfunction

  task automatic send_beat(input logic f, input logic [TagW-1:0] x, input logic [TagW-1:0] y);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = f;
    sector_x_i = x;
    sector_y_i = y;
    do @(posedge clk_i); while (in_stall_o);
    expected_slots.push_back(access_cache(f, x, y));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_slots.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i = rst_ni && !quiet && ($urandom_range(0, 99) < 14);
  end

  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b slot=%0d", $time, hit_o, slot_index_o);
        errors++;
      end else begin
        want = expected_slots.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          errors++;
        end
        if (slot_index_o !== want.slot) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, slot_index_o);
          errors++;
        end
      end
    end
  end

  task automatic test_clear();
    send_beat(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // extremes of both tags, plus pairs that differ in only one tag
  task automatic test_fill_free_slots();
    logic [TagW-1:0] fx [16] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                 32'd5, 32'd5, 32'd6, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'd1, -32'sd2, 32'd123456};
    logic [TagW-1:0] fy [16] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                                 32'd7, 32'd8, 32'd7, 32'hAAAA_AAAA, 32'h5555_5555,
                                 32'd1, 32'd3, -32'sd654321};
    for (int i = 0; i < 16; i++) send_beat(FUNC_LOOKUP, fx[i], fy[i]);
  endtask

  task automatic test_hits();
    send_beat(FUNC_LOOKUP, 32'h8000_0000, 32'h8000_0000);
    send_beat(FUNC_LOOKUP, 32'd123456, -32'sd654321);
  endtask

  task automatic test_lru_eviction();
    send_beat(FUNC_LOOKUP, 32'hDEAD_BEEF, 32'h0BAD_F00D);
  endtask

  task automatic test_drain_pause();
    send_beat(FUNC_LOOKUP, 32'd5, 32'd7);
    wait_all_results();
    send_beat(FUNC_LOOKUP, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_beat(FUNC_CLEAR, 32'h0, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    logic [TagW-1:0] pool_x [32];
    logic [TagW-1:0] pool_y [32];
    int span;
    int pick;
    int r;
    span = 8;
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 0) begin
        for (int k = 0; k < 32; k++) begin
          if (k > 0 && $urandom_range(0, 3) == 0) begin
            // near miss: one tag bit flipped
            pool_x[k] = pool_x[k-1];
            pool_y[k] = pool_y[k-1];
            if ($urandom_range(0, 1) == 1) pool_x[k] = pool_x[k] ^ (32'h1 << $urandom_range(0, 31));
            else pool_y[k] = pool_y[k] ^ (32'h1 << $urandom_range(0, 31));
          end else begin
            pool_x[k] = $urandom;
            pool_y[k] = $urandom;
          end
        end
        case ($urandom_range(0, 2))
          0: span = 8;
          1: span = 20;
          default: span = 32;
        endcase
      end
      quiet = (n >= 500 && n < 700);
      if (n % 200 == 199) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_beat(FUNC_CLEAR, $urandom, $urandom);
      end else if (r < 12) begin
        send_beat(FUNC_LOOKUP, $urandom, $urandom);
      end else begin
        pick = $urandom_range(0, span - 1);
        send_beat(FUNC_LOOKUP, pool_x[pick], pool_y[pick]);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_clear();
    test_fill_free_slots();
    test_hits();
    test_lru_eviction();
    test_drain_pause();
    test_random_traffic(1330);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    k = 0;
    while (k < 2000 && expected_slots.size() != 0) begin
      @(posedge clk_i);
      k++;
    end
    repeat (SLOTS + 8) @(posedge clk_i);
    if (expected_slots.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_slots.size());
      errors++;
    end

    $display("Checked %0d result beats: %0d hits, %0d allocations (%0d LRU evictions)",
             beats_checked, hits_seen, allocs_seen, evictions_seen);
    $display("Clears issued: %0d, mismatches: %0d", clears_seen, errors);
    if (errors == 0) begin
      $display("[lru_tag_cache_lookup] OK");
    end else begin
      $display("[lru_tag_cache_lookup] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("[lru_tag_cache_lookup] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ltc_pkg.sv
src/ltc_ram.sv
src/lru_tag_cache_lookup.sv
src/ltc_checker.sv
tb/lru_tag_cache_lookup_tb.sv
